### hw/rtl/dpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpd_pkg: shared constants and tables for the DPSK phase demapper
// Field widths, angle constants and the half-degree sine and cosine tables
// used by the octant arctangent search.
// ----------------------------------------------------------------------------
package dpd_pkg;

	// Default sizes handed to the top level.
	localparam int CARRIERS_DEF  = 64;
	localparam int BIN_WIDTH_DEF = 16;

	// Fixed field widths.
	localparam int CARRIER_W = 6;
	localparam int SYM_W     = 6;
	localparam int PHASE_W   = 9;
	localparam int BPS_W     = 3;

	// Symbol size register.
	localparam logic [BPS_W-1:0] BPS_RESET = 3'd2;
	localparam logic [BPS_W-1:0] BPS_MIN   = 3'd1;
	localparam logic [BPS_W-1:0] BPS_MAX   = 3'd6;

	// Angles in whole degrees.
	localparam logic [PHASE_W-1:0] DEG_90  = 9'd90;
	localparam logic [PHASE_W-1:0] DEG_180 = 9'd180;
	localparam logic [PHASE_W-1:0] DEG_360 = 9'd360;

	// Octant search: 45 half-degree boundaries, found in six binary steps.
	localparam int                OCT_STEPS   = 45;
	localparam int                NIDX_W      = 6;
	localparam int                SRCH_LEVELS = 6;
	localparam logic [NIDX_W-1:0] OCT_STEPS_N = 6'd45;

	// Q2.62 trig constants, split in two 31-bit halves for the multipliers.
	localparam int          Q_W     = 62;
	localparam int          HALF_W  = 31;
	localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C234;
	localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;

	// Division by 360 as a multiply: exact for numerators below 2^16.
	localparam int                  DIV_W        = 15;
	localparam int                  DIV360_W     = 16;
	localparam logic [DIV360_W-1:0] DIV360_MUL   = 16'd46604;
	localparam int                  DIV360_SHIFT = 24;

	typedef logic [OCT_STEPS-1:0][Q_W-1:0] trig_tab_t;

	// Q2.62 product, truncated.
	function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// Divide a Taylor term by its small term number.
	function automatic logic [63:0] div_term(logic [63:0] v, int n);
		case (n)
			1: return v / 64'd1;
			2: return v / 64'd2;
			3: return v / 64'd3;
			4: return v / 64'd4;
			5: return v / 64'd5;
			6: return v / 64'd6;
			7: return v / 64'd7;
			8: return v / 64'd8;
			9: return v / 64'd9;
			10: return v / 64'd10;
			11: return v / 64'd11;
			12: return v / 64'd12;
			13: return v / 64'd13;
			14: return v / 64'd14;
			15: return v / 64'd15;
			16: return v / 64'd16;
			17: return v / 64'd17;
			18: return v / 64'd18;
			19: return v / 64'd19;
			20: return v / 64'd20;
			21: return v / 64'd21;
			22: return v / 64'd22;
			23: return v / 64'd23;
			24: return v / 64'd24;
			25: return v / 64'd25;
			26: return v / 64'd26;
			27: return v / 64'd27;
			28: return v / 64'd28;
			29: return v / 64'd29;
			30: return v / 64'd30;
			default: return v;
		endcase
	endfunction

	// Sine or cosine of (k + 0.5) degrees by a 30-term Taylor series.
	function automatic trig_tab_t build_trig(bit want_cos);
		trig_tab_t   tab;
		logic [63:0] unit;
		logic [63:0] b;
		logic [63:0] t;
		logic [63:0] c;
		logic [63:0] s;
		unit = PI_Q62 / 64'd360;
		for (int k = 0; k < OCT_STEPS; k++) begin
			b = unit * 64'(2 * k + 1);
			t = ONE_Q62;
			c = ONE_Q62;
			s = 64'd0;
			for (int n = 1; n <= 30; n++) begin
				t = div_term(mul_q62(t, b), n);
				case (n & 3)
					1: s = s + t;
					2: c = c - t;
					3: s = s - t;
					default: c = c + t;
				endcase
			end
			tab[k] = want_cos ? c[Q_W-1:0] : s[Q_W-1:0];
		end
		return tab;
	endfunction

	localparam trig_tab_t SIN_TAB = build_trig(1'b0);
	localparam trig_tab_t COS_TAB = build_trig(1'b1);

endpackage
`default_nettype wire

### hw/rtl/dpsk_phase_demapper.sv
`timescale 1ns / 1ps
`default_nettype none
// A word passes stages 1 and 2, the search stages, stages 15 to 17 and the output register.
// Throughput: one word per cycle; the pipeline stalls only when the output is held.
// Depth is set by the six-step arctangent search, two stages per step.
// Reset clears all valid bits and sets bits_per_symbol to 2.
// The per-carrier phase store is not cleared; a carrier must see its reference first.
// ----------------------------------------------------------------------------
// dpsk_phase_demapper
// Differential M-PSK demapper: rounds each bin's phase to whole degrees,
// subtracts the carrier's previous phase and maps the difference to a symbol.
// ----------------------------------------------------------------------------
module dpsk_phase_demapper #(
	parameter int CARRIERS  = dpd_pkg::CARRIERS_DEF,
	parameter int BIN_WIDTH = dpd_pkg::BIN_WIDTH_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire  [dpd_pkg::BPS_W-1:0]        cfg_wdata,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  [dpd_pkg::CARRIER_W-1:0]    carrier,
	input  wire  signed [BIN_WIDTH-1:0]      bin_re,
	input  wire  signed [BIN_WIDTH-1:0]      bin_im,
	input  wire                              reference,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [dpd_pkg::CARRIER_W-1:0]    out_carrier,
	output logic [dpd_pkg::SYM_W-1:0]        symbol,
	output logic [dpd_pkg::PHASE_W-1:0]      phase_diff
);
	import dpd_pkg::*;

	localparam int ADDR_W = (CARRIERS > 1) ? $clog2(CARRIERS) : 1;
	localparam int PP_W   = BIN_WIDTH + HALF_W;
	localparam int CMP_W  = BIN_WIDTH + Q_W + 1;
	localparam int PROD_W = DIV_W + DIV360_W;

	// Item in the octant search: folded magnitudes and the boundary count so far.
	typedef struct packed {
		logic [CARRIER_W-1:0] carrier;
		logic                 reference;
		logic                 swapped;
		logic                 re_neg;
		logic                 im_neg;
		logic [BIN_WIDTH-1:0] x;
		logic [BIN_WIDTH-1:0] y;
		logic [NIDX_W-1:0]    n;
	} oct_t;

	// Partial products of one boundary test.
	typedef struct packed {
		oct_t              item;
		logic              ok;
		logic [NIDX_W-1:0] cand;
		logic [PP_W-1:0]   yc_hi;
		logic [PP_W-1:0]   yc_lo;
		logic [PP_W-1:0]   xs_hi;
		logic [PP_W-1:0]   xs_lo;
	} mul_t;

	typedef struct packed {
		logic [CARRIER_W-1:0] carrier;
		logic                 reference;
		logic [PHASE_W-1:0]   phase;
	} ph_t;

	typedef struct packed {
		logic [CARRIER_W-1:0] carrier;
		logic [PHASE_W-1:0]   diff;
	} diff_t;

	// Select the next boundary and form y*cos and x*sin in 31-bit halves.
	function automatic mul_t mul_step(oct_t d, logic [NIDX_W-1:0] step);
		mul_t              m;
		logic [NIDX_W-1:0] idx;
		logic [Q_W-1:0]    c;
		logic [Q_W-1:0]    s;
		m.item = d;
		m.cand = d.n + step;
		m.ok   = (m.cand <= OCT_STEPS_N);
		idx    = m.ok ? (m.cand - NIDX_W'(1)) : (OCT_STEPS_N - NIDX_W'(1));
		c      = COS_TAB[idx];
		s      = SIN_TAB[idx];
		m.yc_hi = PP_W'(d.y) * PP_W'(c[Q_W-1:HALF_W]);
		m.yc_lo = PP_W'(d.y) * PP_W'(c[HALF_W-1:0]);
		m.xs_hi = PP_W'(d.x) * PP_W'(s[Q_W-1:HALF_W]);
		m.xs_lo = PP_W'(d.x) * PP_W'(s[HALF_W-1:0]);
		return m;
	endfunction

	// Sum the halves and keep the candidate count if the bin lies above the boundary.
	function automatic oct_t cmp_step(mul_t m);
		oct_t             d;
		logic [CMP_W-1:0] lhs;
		logic [CMP_W-1:0] rhs;
		d   = m.item;
		lhs = (CMP_W'(m.yc_hi) << HALF_W) + CMP_W'(m.yc_lo);
		rhs = (CMP_W'(m.xs_hi) << HALF_W) + CMP_W'(m.xs_lo);
		if (m.ok && (lhs > rhs)) begin
			d.n = m.cand;
		end
		return d;
	endfunction

	// Configuration register.
	logic [BPS_W-1:0] bps_q;
	logic [BPS_W-1:0] bps_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bps_q <= BPS_RESET;
		end else if (cfg_we) begin
			bps_q <= cfg_wdata;
		end
	end

	// Out-of-range codes saturate to the valid range.
	always_comb begin
		if (bps_q < BPS_MIN) begin
			bps_eff = BPS_MIN;
		end else if (bps_q > BPS_MAX) begin
			bps_eff = BPS_MAX;
		end else begin
			bps_eff = bps_q;
		end
	end

	// Pipeline registers and valid bits.
	oct_t  fold_s1, swap_s2;
	logic  v_s1, v_s2;
	mul_t  mul_s [SRCH_LEVELS];
	oct_t  cmp_s [SRCH_LEVELS];
	logic  mul_v_s [SRCH_LEVELS];
	logic  cmp_v_s [SRCH_LEVELS];
	ph_t   phase_s15, rd_s16;
	logic  v_s15, v_s16, v_s17;
	logic  [PHASE_W-1:0] rdat_s16;
	diff_t diff_s17;

	// Stage enables: a stage loads when it is empty or its successor loads.
	logic en_out, en_s17, en_s16, en_s15, en_s2, en_s1;
	logic mul_en [SRCH_LEVELS];
	logic cmp_en [SRCH_LEVELS];

	always_comb begin
		en_out = !out_valid || out_ready;
		en_s17 = !v_s17 || en_out;
		en_s16 = !v_s16 || en_s17;
		en_s15 = !v_s15 || en_s16;
		cmp_en[SRCH_LEVELS-1] = !cmp_v_s[SRCH_LEVELS-1] || en_s15;
		mul_en[SRCH_LEVELS-1] = !mul_v_s[SRCH_LEVELS-1] || cmp_en[SRCH_LEVELS-1];
		for (int lv = SRCH_LEVELS - 2; lv >= 0; lv--) begin
			cmp_en[lv] = !cmp_v_s[lv] || mul_en[lv+1];
			mul_en[lv] = !mul_v_s[lv] || cmp_en[lv];
		end
		en_s2 = !v_s2 || mul_en[0];
		en_s1 = !v_s1 || en_s2;
	end

	assign in_ready = en_s1;

	// Stage 1: magnitudes and signs; carriers beyond the store are dropped here.
	logic [BIN_WIDTH-1:0] re_u, im_u;
	oct_t                 fold_d;
	logic                 in_range;

	always_comb begin
		re_u             = bin_re;
		im_u             = bin_im;
		in_range         = (32'(carrier) < CARRIERS);
		fold_d.carrier   = carrier;
		fold_d.reference = reference;
		fold_d.swapped   = 1'b0;
		fold_d.re_neg    = re_u[BIN_WIDTH-1];
		fold_d.im_neg    = im_u[BIN_WIDTH-1];
		fold_d.x         = re_u[BIN_WIDTH-1] ? (~re_u + BIN_WIDTH'(1)) : re_u;
		fold_d.y         = im_u[BIN_WIDTH-1] ? (~im_u + BIN_WIDTH'(1)) : im_u;
		fold_d.n         = '0;
	end

	// Stage 2: fold into the first octant so that x holds the larger magnitude.
	oct_t swap_d;

	always_comb begin
		swap_d = fold_s1;
		if (fold_s1.y > fold_s1.x) begin
			swap_d.swapped = 1'b1;
			swap_d.x       = fold_s1.y;
			swap_d.y       = fold_s1.x;
		end
	end

	// Search stages: each level halves the range of the boundary count.
	oct_t src_d [SRCH_LEVELS];
	logic src_v [SRCH_LEVELS];
	mul_t mul_d [SRCH_LEVELS];
	oct_t cmp_d [SRCH_LEVELS];

	always_comb begin
		for (int lv = 0; lv < SRCH_LEVELS; lv++) begin
			if (lv == 0) begin
				src_d[lv] = swap_s2;
				src_v[lv] = v_s2;
			end else begin
				src_d[lv] = cmp_s[lv-1];
				src_v[lv] = cmp_v_s[lv-1];
			end
			mul_d[lv] = mul_step(src_d[lv], NIDX_W'(1) << (SRCH_LEVELS - 1 - lv));
			cmp_d[lv] = cmp_step(mul_s[lv]);
		end
	end

	// Stage 15: unfold the octant count into a phase of 0 to 359 degrees.
	oct_t               oct_last;
	logic [PHASE_W-1:0] a0, a1;
	ph_t                phase_d;

	always_comb begin
		oct_last          = cmp_s[SRCH_LEVELS-1];
		a0                = oct_last.swapped ? (DEG_90 - PHASE_W'(oct_last.n))
		                                     : PHASE_W'(oct_last.n);
		a1                = oct_last.re_neg ? (DEG_180 - a0) : a0;
		phase_d.carrier   = oct_last.carrier;
		phase_d.reference = oct_last.reference;
		phase_d.phase     = (oct_last.im_neg && (a1 != '0)) ? (DEG_360 - a1) : a1;
	end

	// Phase store, read as an item enters stage 16, written as it leaves.
	logic [PHASE_W-1:0] prev_mem [CARRIERS];
	logic [ADDR_W-1:0]  rd_addr, wr_addr;
	logic               wr_en;
	logic               last_v_q;
	logic [CARRIER_W-1:0] last_carrier_q;
	logic [PHASE_W-1:0]   last_phase_q;
	logic [PHASE_W-1:0]   prev_sel;
	diff_t                diff_d;

	assign rd_addr = ADDR_W'(phase_s15.carrier);
	assign wr_addr = ADDR_W'(rd_s16.carrier);
	assign wr_en   = v_s16 && en_s17;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			prev_mem[wr_addr] <= rd_s16.phase;
		end
		if (en_s16) begin
			rdat_s16 <= prev_mem[rd_addr];
		end
	end

	// The last write bypasses the store for an item that read in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_v_q <= 1'b0;
		end else if (wr_en) begin
			last_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			last_carrier_q <= rd_s16.carrier;
			last_phase_q   <= rd_s16.phase;
		end
	end

	// Stage 17: wrapped phase difference.
	always_comb begin
		prev_sel = (last_v_q && (last_carrier_q == rd_s16.carrier)) ? last_phase_q : rdat_s16;
		diff_d.carrier = rd_s16.carrier;
		diff_d.diff    = (rd_s16.phase >= prev_sel) ? (rd_s16.phase - prev_sel)
		                                            : (rd_s16.phase + DEG_360 - prev_sel);
	end

	// Output stage: symbol = floor((diff * M + 180) / 360) mod M.
	logic [DIV_W-1:0]  num;
	logic [PROD_W-1:0] quot_prod;
	logic [SYM_W-1:0]  sym_d;

	always_comb begin
		num       = (DIV_W'(diff_s17.diff) << bps_eff) + DIV_W'(DEG_180);
		quot_prod = PROD_W'(num) * PROD_W'(DIV360_MUL);
		sym_d     = SYM_W'(quot_prod[PROD_W-1:DIV360_SHIFT]) & ~({SYM_W{1'b1}} << bps_eff);
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s15     <= 1'b0;
			v_s16     <= 1'b0;
			v_s17     <= 1'b0;
			out_valid <= 1'b0;
			for (int lv = 0; lv < SRCH_LEVELS; lv++) begin
				mul_v_s[lv] <= 1'b0;
				cmp_v_s[lv] <= 1'b0;
			end
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid && in_range;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			for (int lv = 0; lv < SRCH_LEVELS; lv++) begin
				if (mul_en[lv]) begin
					mul_v_s[lv] <= src_v[lv];
				end
				if (cmp_en[lv]) begin
					cmp_v_s[lv] <= mul_v_s[lv];
				end
			end
			if (en_s15) begin
				v_s15 <= cmp_v_s[SRCH_LEVELS-1];
			end
			if (en_s16) begin
				v_s16 <= v_s15;
			end
			// A reference word only updates the store.
			if (en_s17) begin
				v_s17 <= v_s16 && !rd_s16.reference;
			end
			if (en_out) begin
				out_valid <= v_s17;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			fold_s1 <= fold_d;
		end
		if (en_s2) begin
			swap_s2 <= swap_d;
		end
		for (int lv = 0; lv < SRCH_LEVELS; lv++) begin
			if (mul_en[lv]) begin
				mul_s[lv] <= mul_d[lv];
			end
			if (cmp_en[lv]) begin
				cmp_s[lv] <= cmp_d[lv];
			end
		end
		if (en_s15) begin
			phase_s15 <= phase_d;
		end
		if (en_s16) begin
			rd_s16 <= phase_s15;
		end
		if (en_s17) begin
			diff_s17 <= diff_d;
		end
		if (en_out) begin
			out_carrier <= diff_s17.carrier;
			symbol      <= sym_d;
			phase_diff  <= diff_s17.diff;
		end
	end

	// The input side only blocks when the output word is held.
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled while the output is free");

	// The unfolded phase stays within one turn.
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s15 |-> (phase_s15.phase < DEG_360))
		else $error("phase out of range");

	// The search never counts past the last boundary.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_v_s[SRCH_LEVELS-1] |-> (cmp_s[SRCH_LEVELS-1].n <= OCT_STEPS_N))
		else $error("octant count out of range");

	// Offered results carry a wrapped difference and a symbol below M.
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((phase_diff < DEG_360) && ((symbol >> bps_eff) == '0)))
		else $error("result out of range");

	// A write to the store always comes from a word leaving stage 16.
	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> last_v_q && (last_carrier_q == $past(rd_s16.carrier)))
		else $error("bypass register does not follow the store write");

endmodule
`default_nettype wire
